### rtl/bsts_pkg.sv
// Shared types and constants for the bit scan / bit test / byte swap unit.
// No dependencies.
package bsts_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned IndexWidth = 6;

   typedef enum logic [2:0] {
      KIND_BSF   = 3'd0,
      KIND_BSR   = 3'd1,
      KIND_BT    = 3'd2,
      KIND_BTC   = 3'd3,
      KIND_BTR   = 3'd4,
      KIND_BTS   = 3'd5,
      KIND_BSWAP = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_BYTE  = 2'd0,
      SIZE_WORD  = 2'd1,
      SIZE_DWORD = 2'd2,
      SIZE_QWORD = 2'd3
   } size_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [1:0]           size_code;
      logic [DataWidth-1:0] dest_value;
      logic [DataWidth-1:0] src_value;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result_value;
      logic                 write_back;
      logic                 zf_value;
      logic                 zf_written;
      logic                 cf_value;
      logic                 cf_written;
      logic                 illegal;
   } rsp_type;

   function automatic logic [DataWidth-1:0] size_mask(input size_type sc);
      logic [DataWidth-1:0] m;
      unique case (sc)
         SIZE_BYTE:  m = {{(DataWidth-8){1'b0}}, {8{1'b1}}};
         SIZE_WORD:  m = {{(DataWidth-16){1'b0}}, {16{1'b1}}};
         SIZE_DWORD: m = {{(DataWidth-32){1'b0}}, {32{1'b1}}};
         default:    m = {DataWidth{1'b1}};
      endcase
      return m;
   endfunction

endpackage

### rtl/bsts_scan.sv
// Lowest / highest set bit finder over a 64-bit value, six halving steps.
// Depends on bsts_pkg.
module bsts_scan (
   input  logic [bsts_pkg::DataWidth-1:0]  scan_value,
   input  logic                            reverse,
   output logic [bsts_pkg::IndexWidth-1:0] scan_index
);

   logic [31:0] lo1, hi1;
   logic [15:0] lo2, hi2;
   logic [7:0]  lo3, hi3;
   logic [3:0]  lo4, hi4;
   logic [1:0]  lo5, hi5;
   logic [bsts_pkg::IndexWidth-1:0] lo_idx, hi_idx;

   // lowest set bit: step into the upper half when the lower half is empty
   always_comb begin
      lo_idx[5] = (scan_value[31:0] == 32'd0);
      lo1       = lo_idx[5] ? scan_value[63:32] : scan_value[31:0];
      lo_idx[4] = (lo1[15:0] == 16'd0);
      lo2       = lo_idx[4] ? lo1[31:16] : lo1[15:0];
      lo_idx[3] = (lo2[7:0] == 8'd0);
      lo3       = lo_idx[3] ? lo2[15:8] : lo2[7:0];
      lo_idx[2] = (lo3[3:0] == 4'd0);
      lo4       = lo_idx[2] ? lo3[7:4] : lo3[3:0];
      lo_idx[1] = (lo4[1:0] == 2'd0);
      lo5       = lo_idx[1] ? lo4[3:2] : lo4[1:0];
      lo_idx[0] = ~lo5[0];
   end

   // highest set bit: step into the upper half when it holds anything
   always_comb begin
      hi_idx[5] = (scan_value[63:32] != 32'd0);
      hi1       = hi_idx[5] ? scan_value[63:32] : scan_value[31:0];
      hi_idx[4] = (hi1[31:16] != 16'd0);
      hi2       = hi_idx[4] ? hi1[31:16] : hi1[15:0];
      hi_idx[3] = (hi2[15:8] != 8'd0);
      hi3       = hi_idx[3] ? hi2[15:8] : hi2[7:0];
      hi_idx[2] = (hi3[7:4] != 4'd0);
      hi4       = hi_idx[2] ? hi3[7:4] : hi3[3:0];
      hi_idx[1] = (hi4[3:2] != 2'd0);
      hi5       = hi_idx[1] ? hi4[3:2] : hi4[1:0];
      hi_idx[0] = hi5[1];
   end

   assign scan_index = reverse ? hi_idx : lo_idx;

endmodule

### rtl/bsts_exec.sv
// Single-pass execute logic: scans, bit tests and byte swap for one request.
// Depends on bsts_pkg and bsts_scan.
module bsts_exec (
   input  bsts_pkg::req_type req,
   output bsts_pkg::rsp_type rsp
);

   bsts_pkg::kind_type             kind;
   bsts_pkg::size_type             size;
   logic [bsts_pkg::DataWidth-1:0] mask;
   logic [bsts_pkg::DataWidth-1:0] scan_src;
   logic [bsts_pkg::IndexWidth-1:0] scan_index;
   logic [bsts_pkg::IndexWidth-1:0] bit_index;
   logic [bsts_pkg::DataWidth-1:0] bit_sel;
   logic [bsts_pkg::DataWidth-1:0] swap32;
   logic [bsts_pkg::DataWidth-1:0] swap64;

   assign kind     = bsts_pkg::kind_type'(req.kind);
   assign size     = bsts_pkg::size_type'(req.size_code);
   assign mask     = bsts_pkg::size_mask(size);
   assign scan_src = req.src_value & mask;

   bsts_scan u_scan (
      .scan_value (scan_src),
      .reverse    (kind == bsts_pkg::KIND_BSR),
      .scan_index (scan_index)
   );

   // bit index wraps at the operand width
   always_comb begin
      unique case (size)
         bsts_pkg::SIZE_WORD:  bit_index = {2'b00, req.src_value[3:0]};
         bsts_pkg::SIZE_DWORD: bit_index = {1'b0, req.src_value[4:0]};
         default:              bit_index = req.src_value[5:0];
      endcase
   end

   assign bit_sel = {{(bsts_pkg::DataWidth-1){1'b0}}, 1'b1} << bit_index;

   assign swap32 = {32'd0, req.dest_value[7:0], req.dest_value[15:8],
                    req.dest_value[23:16], req.dest_value[31:24]};
   assign swap64 = {req.dest_value[7:0],   req.dest_value[15:8],
                    req.dest_value[23:16], req.dest_value[31:24],
                    req.dest_value[39:32], req.dest_value[47:40],
                    req.dest_value[55:48], req.dest_value[63:56]};

   always_comb begin
      rsp = '0;
      unique case (kind)
         bsts_pkg::KIND_BSF, bsts_pkg::KIND_BSR: begin
            rsp.zf_written = 1'b1;
            if (scan_src == '0) begin
               rsp.zf_value = 1'b1;
            end else begin
               rsp.result_value = {{(bsts_pkg::DataWidth-bsts_pkg::IndexWidth){1'b0}},
                                   scan_index};
               rsp.write_back   = 1'b1;
            end
         end
         bsts_pkg::KIND_BT, bsts_pkg::KIND_BTC, bsts_pkg::KIND_BTR,
         bsts_pkg::KIND_BTS: begin
            if (size == bsts_pkg::SIZE_BYTE) begin
               rsp.illegal = 1'b1;
            end else begin
               rsp.cf_written = 1'b1;
               rsp.cf_value   = |(req.dest_value & bit_sel);
               rsp.write_back = (kind != bsts_pkg::KIND_BT);
               priority case (kind)
                  bsts_pkg::KIND_BTC: rsp.result_value = (req.dest_value ^ bit_sel) & mask;
                  bsts_pkg::KIND_BTR: rsp.result_value = (req.dest_value & ~bit_sel) & mask;
                  bsts_pkg::KIND_BTS: rsp.result_value = (req.dest_value | bit_sel) & mask;
                  default:            rsp.result_value = '0;
               endcase
            end
         end
         bsts_pkg::KIND_BSWAP: begin
            unique case (size)
               bsts_pkg::SIZE_BYTE:  rsp.illegal = 1'b1;
               bsts_pkg::SIZE_WORD:  rsp.write_back = 1'b1;
               bsts_pkg::SIZE_DWORD: begin
                  rsp.write_back   = 1'b1;
                  rsp.result_value = swap32;
               end
               default: begin
                  rsp.write_back   = 1'b1;
                  rsp.result_value = swap64;
               end
            endcase
         end
         default: rsp.illegal = 1'b1;
      endcase
   end

endmodule

### rtl/x86_bit_scan_test_swap_unit_top.sv
// Top level of the x86 bit scan / bit test / byte swap unit.
// Depends on bsts_pkg and bsts_exec.
//
// Usage:
//   Request channel (req_*): kind, operand size code and the two fetched
//   operands; a request is taken on a clock edge with req_valid high and
//   req_stall low.
//   Response channel (rsp_*): destination value, write enable, ZF / CF values
//   with their write enables, and the illegal flag; a response is taken on
//   an edge with rsp_valid high and rsp_stall low.
//   Path: a request goes into the input register, then through the
//   single-pass execute logic into the response register.
//   Throughput: one request per cycle, sustained, as long as the receiver
//   takes responses; the execute logic has no loop or shared unit.
//   Stall: a stalled response holds in the response register; the input
//   register keeps accepting until it too is full, then req_stall rises in
//   the same cycle as rsp_stall.
//   Reset: synchronous, clears both valid flags; no request is in flight
//   afterwards and no clearing pass is needed.
module x86_bit_scan_test_swap_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_size_code,
   input  logic [63:0] req_dest_value,
   input  logic [63:0] req_src_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_value,
   output logic        rsp_write_back,
   output logic        rsp_zf_value,
   output logic        rsp_zf_written,
   output logic        rsp_cf_value,
   output logic        rsp_cf_written,
   output logic        rsp_illegal
);

   bsts_pkg::req_type req_ff;
   bsts_pkg::req_type req_in;
   logic              req_valid_ff;
   bsts_pkg::rsp_type rsp_ff;
   bsts_pkg::rsp_type rsp_in;
   logic              rsp_valid_ff;
   logic              rsp_hold;

   assign rsp_hold  = rsp_valid_ff && rsp_stall;
   assign req_stall = req_valid_ff && rsp_hold;

   assign req_in = '{kind:       req_kind,
                     size_code:  req_size_code,
                     dest_value: req_dest_value,
                     src_value:  req_src_value};

   bsts_exec u_exec (
      .req (req_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_in;
      end
   end

   // advance the response register whenever it is empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_hold) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_hold && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_ff.result_value;
   assign rsp_write_back   = rsp_ff.write_back;
   assign rsp_zf_value     = rsp_ff.zf_value;
   assign rsp_zf_written   = rsp_ff.zf_written;
   assign rsp_cf_value     = rsp_ff.cf_value;
   assign rsp_cf_written   = rsp_ff.cf_written;
   assign rsp_illegal      = rsp_ff.illegal;

   a_illegal_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal |->
         !rsp_write_back && !rsp_zf_written && !rsp_cf_written)
      else $error("illegal response also updates state");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_back |-> rsp_result_value == 64'd0)
      else $error("result value set without write back");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_zf_written && rsp_cf_written))
      else $error("both flags written by one response");

   a_input_loaded: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_valid_ff)
      else $error("accepted request not captured");

endmodule
